// ----- hw/rtl/vbs_pkg.sv -----
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types and codes for the version bound satisfiability checker.
// ----------------------------------------------------------------------------
package vbs_pkg;

  // Comparator operator codes.
  typedef enum logic [2:0] {
    KIND_EQ = 3'd0,
    KIND_GT = 3'd1,
    KIND_GE = 3'd2,
    KIND_LT = 3'd3,
    KIND_LE = 3'd4
  } kind_t;

  // A version triple. Packed major first, so an unsigned compare of the
  // whole word gives the lexicographic order.
  typedef struct packed {
    logic [31:0] major;
    logic [31:0] minor;
    logic [31:0] patch;
  } triple_t;

  // Folded bounds of one complete set, handed from fold to judge.
  typedef struct packed {
    triple_t lower;
    triple_t upper;
    logic    lower_exclusive;
    logic    lower_seen;
    logic    upper_inclusive;
    logic    upper_seen;
    logic    exact_conflict;
  } snap_t;

endpackage

// ----- hw/rtl/version_bound_satisfiability.sv -----
// ----------------------------------------------------------------------------
// version_bound_satisfiability
// Folds version comparators into lower/upper bounds and an exact-match
// record, and gives one satisfiability verdict per set on its last item.
// ----------------------------------------------------------------------------
// Throughput: one comparator per cycle, except that a last item waits while the
//   judge cannot take its snapshot; the fold of the bounds is one pass.
// Path: a last item passes the input, snapshot and output registers in turn.
// Reset: synchronous, active low; clears all valid flags and the seen flags of
//   the bound record (not its values), and no clearing pass is needed.
// ----------------------------------------------------------------------------
module version_bound_satisfiability (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [31:0] in_ver_major,
  input  logic [31:0] in_ver_minor,
  input  logic [31:0] in_ver_patch,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_satisfiable
);

  logic             a_valid_r;
  logic [2:0]       a_kind_r;
  vbs_pkg::triple_t a_ver_r;
  logic             a_last_r;
  logic             fold_go, snap_ready;
  vbs_pkg::snap_t   snap;

  // Items that do not end a set always fold; a last item waits for the judge.
  assign fold_go  = a_valid_r && (!a_last_r || snap_ready);
  assign in_ready = !a_valid_r || fold_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid_r <= 1'b1;
    end else if (fold_go) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_kind_r      <= in_kind;
      a_ver_r.major <= in_ver_major;
      a_ver_r.minor <= in_ver_minor;
      a_ver_r.patch <= in_ver_patch;
      a_last_r      <= in_last_item;
    end
  end

  vbs_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_go   (fold_go),
    .item_kind (a_kind_r),
    .item_ver  (a_ver_r),
    .item_last (a_last_r),
    .snap      (snap)
  );

  vbs_judge u_judge (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap_load       (fold_go && a_last_r),
    .snap_in         (snap),
    .snap_ready      (snap_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_satisfiable (out_satisfiable)
  );

endmodule

// ----- hw/rtl/vbs_fold.sv -----
// ----------------------------------------------------------------------------
// vbs_fold
// Holds the running bounds and the exact-match record, and folds one
// comparator into them per cycle while item_go is high. The folded result is
// offered as a snapshot; on the last comparator of a set the state is cleared.
// ----------------------------------------------------------------------------
module vbs_fold (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_go,
  input  logic [2:0]       item_kind,
  input  vbs_pkg::triple_t item_ver,
  input  logic             item_last,
  output vbs_pkg::snap_t   snap
);

  vbs_pkg::triple_t lower_r, upper_r, exact_r;
  vbs_pkg::triple_t lower_nxt, upper_nxt, exact_nxt;
  logic lower_exclusive_r, lower_seen_r, upper_inclusive_r, upper_seen_r;
  logic exact_seen_r, exact_conflict_r;
  logic lower_exclusive_nxt, lower_seen_nxt, upper_inclusive_nxt, upper_seen_nxt;
  logic exact_seen_nxt, exact_conflict_nxt;

  logic v_gt_lo, v_eq_lo, v_lt_up, v_eq_up, v_ne_ex;
  logic take_lo, take_up, lo_strict, up_incl;
  logic fold_lo, fold_up, fold_ex;

  // Lexicographic compares against the stored triples.
  assign v_gt_lo = item_ver > lower_r;
  assign v_eq_lo = item_ver == lower_r;
  assign v_lt_up = item_ver < upper_r;
  assign v_eq_up = item_ver == upper_r;
  assign v_ne_ex = item_ver != exact_r;

  // Decode the operator into which sides it bounds and how.
  always_comb begin
    fold_lo   = 1'b0;
    fold_up   = 1'b0;
    fold_ex   = 1'b0;
    lo_strict = 1'b0;
    up_incl   = 1'b0;
    case (vbs_pkg::kind_t'(item_kind))
      vbs_pkg::KIND_EQ: begin
        fold_ex = 1'b1;
        fold_lo = 1'b1;
        fold_up = 1'b1;
        up_incl = 1'b1;
      end
      vbs_pkg::KIND_GT: begin
        fold_lo   = 1'b1;
        lo_strict = 1'b1;
      end
      vbs_pkg::KIND_GE: fold_lo = 1'b1;
      vbs_pkg::KIND_LT: fold_up = 1'b1;
      vbs_pkg::KIND_LE: begin
        fold_up = 1'b1;
        up_incl = 1'b1;
      end
      default: ;
    endcase
  end

  // A bound is replaced when it is tighter, or equal and strict beats inclusive.
  assign take_lo = fold_lo &&
                   (!lower_seen_r || v_gt_lo || (v_eq_lo && lo_strict && !lower_exclusive_r));
  assign take_up = fold_up &&
                   (!upper_seen_r || v_lt_up || (v_eq_up && !up_incl && upper_inclusive_r));

  // Folded values for this item.
  always_comb begin
    lower_nxt           = lower_r;
    lower_exclusive_nxt = lower_exclusive_r;
    lower_seen_nxt      = lower_seen_r;
    upper_nxt           = upper_r;
    upper_inclusive_nxt = upper_inclusive_r;
    upper_seen_nxt      = upper_seen_r;
    exact_nxt           = exact_r;
    exact_seen_nxt      = exact_seen_r;
    exact_conflict_nxt  = exact_conflict_r;
    if (take_lo) begin
      lower_nxt           = item_ver;
      lower_exclusive_nxt = lo_strict;
      lower_seen_nxt      = 1'b1;
    end
    if (take_up) begin
      upper_nxt           = item_ver;
      upper_inclusive_nxt = up_incl;
      upper_seen_nxt      = 1'b1;
    end
    if (fold_ex) begin
      if (exact_seen_r) begin
        exact_conflict_nxt = exact_conflict_r || v_ne_ex;
      end else begin
        exact_nxt      = item_ver;
        exact_seen_nxt = 1'b1;
      end
    end
  end

  // Snapshot of the set including the current item.
  assign snap.lower           = lower_nxt;
  assign snap.upper           = upper_nxt;
  assign snap.lower_exclusive = lower_exclusive_nxt;
  assign snap.lower_seen      = lower_seen_nxt;
  assign snap.upper_inclusive = upper_inclusive_nxt;
  assign snap.upper_seen      = upper_seen_nxt;
  assign snap.exact_conflict  = exact_conflict_nxt;

  // Flags; a last item clears them so the next set starts afresh.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_seen_r     <= 1'b0;
      upper_seen_r     <= 1'b0;
      exact_seen_r     <= 1'b0;
      exact_conflict_r <= 1'b0;
    end else if (item_go) begin
      lower_seen_r     <= lower_seen_nxt && !item_last;
      upper_seen_r     <= upper_seen_nxt && !item_last;
      exact_seen_r     <= exact_seen_nxt && !item_last;
      exact_conflict_r <= exact_conflict_nxt && !item_last;
    end
  end

  // Bound values are only read while their seen flag is set.
  always_ff @(posedge clk) begin
    if (item_go) begin
      lower_r           <= lower_nxt;
      lower_exclusive_r <= lower_exclusive_nxt;
      upper_r           <= upper_nxt;
      upper_inclusive_r <= upper_inclusive_nxt;
      exact_r           <= exact_nxt;
    end
  end

  // The record is empty after the last item of a set.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && item_last |=> !lower_seen_r && !upper_seen_r && !exact_seen_r
                             && !exact_conflict_r)
    else $error("fold state not cleared after last item");

  // A conflict can only exist once an exact triple was recorded.
  a_conflict_needs_exact: assert property (@(posedge clk) disable iff (!rst_n)
    exact_conflict_r |-> exact_seen_r)
    else $error("exact conflict without an exact triple");

  // An exact match always leaves both bounds in place.
  a_exact_sets_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    item_go && !item_last && fold_ex |=> lower_seen_r && upper_seen_r)
    else $error("exact match did not set both bounds");

endmodule

// ----- hw/rtl/vbs_judge.sv -----
// ----------------------------------------------------------------------------
// vbs_judge
// Registers the snapshot of a finished set, compares its bounds and holds
// the verdict in the output register until it is transferred.
// ----------------------------------------------------------------------------
module vbs_judge (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           snap_load,
  input  vbs_pkg::snap_t snap_in,
  output logic           snap_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_satisfiable
);

  vbs_pkg::snap_t snap_r;
  logic j_valid_r, out_valid_r, out_sat_r;
  logic j_take, verdict, lo_gt_up, lo_eq_up;

  assign j_take     = j_valid_r && (!out_valid_r || out_ready);
  assign snap_ready = !j_valid_r || j_take;

  // Verdict of the registered set.
  assign lo_gt_up = snap_r.lower > snap_r.upper;
  assign lo_eq_up = snap_r.lower == snap_r.upper;
  always_comb begin
    if (snap_r.exact_conflict) begin
      verdict = 1'b0;
    end else if (!snap_r.lower_seen || !snap_r.upper_seen) begin
      verdict = 1'b1;
    end else if (lo_gt_up) begin
      verdict = 1'b0;
    end else if (lo_eq_up) begin
      verdict = !snap_r.lower_exclusive && snap_r.upper_inclusive;
    end else begin
      verdict = 1'b1;
    end
  end

  // Stage and output valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (snap_load) begin
        j_valid_r <= 1'b1;
      end else if (j_take) begin
        j_valid_r <= 1'b0;
      end
      if (j_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_r <= snap_in;
    end
    if (j_take) begin
      out_sat_r <= verdict;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_satisfiable = out_sat_r;

  // A snapshot is never overwritten before it is judged.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load |-> snap_ready)
    else $error("snapshot overwritten");

  // A waiting snapshot moves to an empty output register at once.
  a_judge_moves: assert property (@(posedge clk) disable iff (!rst_n)
    j_valid_r && !out_valid_r |=> out_valid_r)
    else $error("verdict not produced");

  // The output empties after a transfer when nothing is queued behind it.
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !j_valid_r |=> !out_valid_r)
    else $error("verdict repeated");

endmodule

// ----- dv/version_bound_satisfiability_test.sv -----
// ----------------------------------------------------------------------------
// version_bound_satisfiability_test
// Self-checking bench for the version bound satisfiability checker. Sets of
// comparators are sent over the input channel with random gaps. Each set is
// folded into bounds by a predictor, and every verdict that comes back under
// random stalls is compared with the expected one.
// ----------------------------------------------------------------------------
module version_bound_satisfiability_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Operator codes that the block ignores.
  localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSVD_MID   = 3'd6;
  localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

  localparam int unsigned ITEM_TARGET  = 1450;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 12;

  localparam bit [31:0] C_MAX = 32'hFFFF_FFFF;

  // ----------------------------------------------------------------------------
  // Bound tracker: folds comparators and keeps the verdicts still to arrive.
  // ----------------------------------------------------------------------------
  class bound_verdict_tracker;
    bit [95:0] low_bound;
    bit        low_strict;
    bit        low_valid;
    bit [95:0] high_bound;
    bit        high_incl;
    bit        high_valid;
    bit [95:0] pin_value;
    bit        pin_valid;
    bit        pin_clash;
    bit        verdicts_due[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      low_bound  = '0;
      low_strict = 1'b0;
      low_valid  = 1'b0;
      high_bound = '0;
      high_incl  = 1'b0;
      high_valid = 1'b0;
      pin_value  = '0;
      pin_valid  = 1'b0;
      pin_clash  = 1'b0;
    endfunction

    // A higher floor wins; on a tie a strict floor replaces an inclusive one.
    function void raise_floor(bit [95:0] v, bit strict);
      if (!low_valid || v > low_bound || (v == low_bound && strict && !low_strict)) begin
        low_bound  = v;
        low_strict = strict;
        low_valid  = 1'b1;
      end
    endfunction

    // A lower ceiling wins; on a tie a strict ceiling replaces an inclusive one.
    function void lower_ceiling(bit [95:0] v, bit incl);
      if (!high_valid || v < high_bound || (v == high_bound && !incl && high_incl)) begin
        high_bound = v;
        high_incl  = incl;
        high_valid = 1'b1;
      end
    endfunction

    function bit set_verdict();
      if (pin_clash) return 1'b0;
      if (!low_valid || !high_valid) return 1'b1;
      if (low_bound > high_bound) return 1'b0;
      if (low_bound == high_bound) return !low_strict && high_incl;
      return 1'b1;
    endfunction

    // Notes one accepted comparator.
    function void fold_comparator(logic [2:0] kind, bit [31:0] maj, bit [31:0] mnr,
                                  bit [31:0] pat, bit last);
      bit [95:0] v;
      v = {maj, mnr, pat};
      case (kind)
        vbs_pkg::KIND_EQ: begin
          if (pin_valid) begin
            if (v != pin_value) pin_clash = 1'b1;
          end else begin
            pin_value = v;
            pin_valid = 1'b1;
          end
          raise_floor(v, 1'b0);
          lower_ceiling(v, 1'b1);
        end
        vbs_pkg::KIND_GT: raise_floor(v, 1'b1);
        vbs_pkg::KIND_GE: raise_floor(v, 1'b0);
        vbs_pkg::KIND_LT: lower_ceiling(v, 1'b0);
        vbs_pkg::KIND_LE: lower_ceiling(v, 1'b1);
        default: ;
      endcase
      if (last) begin
        verdicts_due = {verdicts_due, set_verdict()};
        clear_set();
      end
    endfunction

    // Checks one accepted verdict against the oldest one expected.
    function void compare_verdict(logic sat);
      bit want;
      if (verdicts_due.size() == 0) begin
        $error("satisfiable: transfer with no verdict expected, actual %0b", sat);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (sat !== want) begin
          $error("satisfiable: expected %0b, actual %0b", want, sat);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  // ----------------------------------------------------------------------------
  // Signals and the block.
  // ----------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [31:0] in_ver_major = '0;
  logic [31:0] in_ver_minor = '0;
  logic [31:0] in_ver_patch = '0;
  logic        in_last_item = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_satisfiable;

  bound_verdict_tracker tracker = new();
  int unsigned counted_items = 0;
  int unsigned idle_cycles = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;

  version_bound_satisfiability DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_ver_major    (in_ver_major),
    .in_ver_minor    (in_ver_minor),
    .in_ver_patch    (in_ver_patch),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_satisfiable (out_satisfiable)
  );

  // Clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly no pause or a short one, a few long ones, none at all while calm.
  function automatic int unsigned pick_pause(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sends one comparator and waits for its transfer.
  task automatic send_item(logic [2:0] kind, bit [31:0] maj, bit [31:0] mnr,
                           bit [31:0] pat, bit last);
    int unsigned gap;
    gap = pick_pause(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_ver_major <= maj;
    in_ver_minor <= mnr;
    in_ver_patch <= pat;
    in_last_item <= last;
    do @(posedge clk); while (!in_ready);
    tracker.fold_comparator(kind, maj, mnr, pat, last);
    counted_items++;
  endtask

  // A component near the set's base value, or an extreme, or anything.
  function automatic bit [31:0] pick_component(bit [31:0] base);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return C_MAX;
      2, 3:    return $urandom();
      4:       return base + 32'd1;
      5:       return base - 32'd1;
      default: return base;
    endcase
  endfunction

  function automatic bit [31:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return C_MAX;
      2:       return $urandom();
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  // Sends one random set; most comparators sit close together so that ties
  // and crossed bounds are common.
  task automatic send_random_set();
    int unsigned len;
    bit [31:0]   b_maj;
    bit [31:0]   b_mnr;
    bit [31:0]   b_pat;
    logic [2:0]  kind;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
    b_maj = pick_base();
    b_mnr = pick_base();
    b_pat = pick_base();
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        kind = 3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
      else
        kind = 3'($urandom_range(vbs_pkg::KIND_EQ, vbs_pkg::KIND_LE));
      send_item(kind,
                ($urandom_range(0, 3) == 0) ? pick_component(b_maj) : b_maj,
                ($urandom_range(0, 2) == 0) ? pick_component(b_mnr) : b_mnr,
                pick_component(b_pat),
                i == len - 1);
    end
  endtask

  // ----------------------------------------------------------------------------
  // Result side: random stalls and checking of every transfer.
  // ----------------------------------------------------------------------------
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) take_calm = !take_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_pause(take_calm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.compare_verdict(out_satisfiable);
  end

  // Watchdog on cycles without any transfer.
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ----------------------------------------------------------------------------
  // Stimulus.
  // ----------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Single-item set at the lowest triple.
    send_item(vbs_pkg::KIND_EQ, '0, '0, '0, 1'b1);
    // Equal bounds at the top triple with a strict floor.
    send_item(vbs_pkg::KIND_GT, C_MAX, C_MAX, C_MAX, 1'b0);
    send_item(vbs_pkg::KIND_LE, C_MAX, C_MAX, C_MAX, 1'b1);
    // Equal inclusive bounds.
    send_item(vbs_pkg::KIND_GE, 32'd1, 32'd2, 32'd3, 1'b0);
    send_item(vbs_pkg::KIND_LE, 32'd1, 32'd2, 32'd3, 1'b1);
    // Exact match tied with a strict floor, then with a strict ceiling.
    send_item(vbs_pkg::KIND_EQ, 32'd1, 32'd2, 32'd3, 1'b0);
    send_item(vbs_pkg::KIND_GT, 32'd1, 32'd2, 32'd3, 1'b1);
    send_item(vbs_pkg::KIND_LT, 32'd3, 32'd3, 32'd3, 1'b0);
    send_item(vbs_pkg::KIND_EQ, 32'd3, 32'd3, 32'd3, 1'b1);
    // Two exact matches that disagree.
    send_item(vbs_pkg::KIND_EQ, 32'd5, '0, '0, 1'b0);
    send_item(vbs_pkg::KIND_EQ, 32'd5, '0, 32'd1, 1'b1);
    // A discrete gap still counts as satisfiable.
    send_item(vbs_pkg::KIND_GT, 32'd1, '0, '0, 1'b0);
    send_item(vbs_pkg::KIND_LT, 32'd1, '0, 32'd1, 1'b1);
    // Crossed bounds decided by the major field, with minor and patch ordered the other way.
    send_item(vbs_pkg::KIND_GE, 32'd2, '0, '0, 1'b0);
    send_item(vbs_pkg::KIND_LT, 32'd1, C_MAX, C_MAX, 1'b1);
    // Unknown operators, the last of them closing the set.
    send_item(KIND_RSVD_FIRST, 32'd7, 32'd7, 32'd7, 1'b0);
    send_item(KIND_RSVD_MID, 32'hA5A5_A5A5, 32'h5A5A_5A5A, C_MAX, 1'b0);
    send_item(KIND_RSVD_LAST, '0, '0, '0, 1'b1);
    // Ceiling only, and then a strict ceiling at the lowest floor.
    send_item(vbs_pkg::KIND_LT, '0, '0, '0, 1'b1);
    send_item(vbs_pkg::KIND_GE, '0, '0, '0, 1'b0);
    send_item(vbs_pkg::KIND_LT, '0, '0, '0, 1'b1);

    // Random sets, with calm stretches on the sending side now and then.
    while (counted_items < ITEM_TARGET) begin
      send_calm = ($urandom_range(0, 99) < 15);
      send_random_set();
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline to show any stray verdict.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
